### rtl/core/hwd_pkg.sv
package hwd_pkg;

    localparam int MAX_NODES   = 256;
    localparam int END_TOKEN   = 256;
    localparam int TABLE_DEPTH = 256;
    localparam int NODE_W      = $clog2(TABLE_DEPTH);
    localparam int CHILD_W     = 16;
    localparam int ENTRY_W     = 2 * CHILD_W;
    localparam int BYTE_BITS   = 8;
    localparam int BIT_CNT_W   = $clog2(BYTE_BITS);

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_NODE  = 2'd1;
    localparam logic [1:0] REQ_DATA  = 2'd2;

    typedef enum logic [1:0] {
        STAT_DATA      = 2'd0,
        STAT_END       = 2'd1,
        STAT_BAD_COUNT = 2'd2,
        STAT_BAD_CHILD = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRIME,
        ST_WALK,
        ST_FLUSH
    } walk_state_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [14:0]        node_count;
        logic [7:0]         node_index;
        logic signed [15:0] left_child;
        logic signed [15:0] right_child;
        logic [7:0]         data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic [1:0] status;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [7:0] symbol;
        status_t    status;
    } result_t;

    typedef struct packed {
        logic               en;
        logic [NODE_W-1:0]  addr;
        logic [ENTRY_W-1:0] data;
    } ram_wr_t;

    typedef struct packed {
        logic      load;
        out_item_t item;
    } xfer_t;

endpackage

### rtl/core/hwd_tree_ram.sv
module hwd_tree_ram
    import hwd_pkg::*;
(
    input  logic               aclk,
    input  ram_wr_t            wr,
    input  logic [NODE_W-1:0]  rd_addr,
    output logic [ENTRY_W-1:0] rd_data
);

    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/hwd_bit_walker.sv
module hwd_bit_walker
    import hwd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_data,
    input  logic               out_can_load,
    output xfer_t              xfer,
    output ram_wr_t            ram_wr,
    output logic [NODE_W-1:0]  ram_rd_addr,
    input  logic [ENTRY_W-1:0] ram_rd_data
);

    walk_state_t          state_reg, state_next;
    logic [NODE_W-1:0]    walk_node_reg, walk_node_next;
    logic                 done_reg, done_next;
    logic [BYTE_BITS-1:0] shift_reg, shift_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic                 pend_v_reg, pend_v_next;
    result_t              pend_reg, pend_next;

    logic [CHILD_W-1:0]   child;
    logic [CHILD_W-1:0]   leaf_val;
    logic                 res_hit;
    logic                 res_stop;
    result_t              res;
    logic [NODE_W-1:0]    node_step;
    logic                 accept;
    logic [ENTRY_W-1:0]   end_word;

    assign end_word = {2{CHILD_W'(-(END_TOKEN + 1))}};
    assign accept   = s_valid && s_ready;

    // Decode one bit against the entry of the current node.
    always_comb begin
        child     = shift_reg[0] ? ram_rd_data[ENTRY_W-1:CHILD_W]
                                 : ram_rd_data[CHILD_W-1:0];
        leaf_val  = ~child;
        res_hit   = 1'b0;
        res_stop  = 1'b0;
        res       = '{symbol: '0, status: STAT_DATA};
        node_step = '0;
        if (!child[CHILD_W-1]) begin
            if (child < CHILD_W'(MAX_NODES)) begin
                node_step = child[NODE_W-1:0];
            end else begin
                res_hit    = 1'b1;
                res_stop   = 1'b1;
                res.status = STAT_BAD_CHILD;
            end
        end else begin
            res_hit = 1'b1;
            if (leaf_val < CHILD_W'(END_TOKEN)) begin
                res.symbol = leaf_val[7:0];
            end else if (leaf_val == CHILD_W'(END_TOKEN)) begin
                res_stop   = 1'b1;
                res.status = STAT_END;
            end else begin
                res_stop   = 1'b1;
                res.status = STAT_BAD_CHILD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            walk_node_reg <= '0;
            done_reg      <= 1'b1;
            pend_v_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            walk_node_reg <= walk_node_next;
            done_reg      <= done_next;
            pend_v_reg    <= pend_v_next;
        end
        shift_reg   <= shift_next;
        bit_cnt_reg <= bit_cnt_next;
        pend_reg    <= pend_next;
    end

    always_comb begin
        state_next     = state_reg;
        walk_node_next = walk_node_reg;
        done_next      = done_reg;
        shift_next     = shift_reg;
        bit_cnt_next   = bit_cnt_reg;
        pend_v_next    = pend_v_reg;
        pend_next      = pend_reg;
        s_ready        = 1'b0;
        xfer           = '{load: 1'b0, item: '{symbol: pend_reg.symbol,
                                                status: pend_reg.status,
                                                last: 1'b0}};
        ram_wr         = '{en: 1'b0, addr: '0, data: '0};
        ram_rd_addr    = walk_node_reg;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    case (s_data.req_type)
                        REQ_START: begin
                            walk_node_next = '0;
                            if (s_data.node_count > 15'(MAX_NODES)) begin
                                done_next   = 1'b1;
                                pend_v_next = 1'b1;
                                pend_next   = '{symbol: '0, status: STAT_BAD_COUNT};
                                state_next  = ST_FLUSH;
                            end else begin
                                ram_wr    = '{en: 1'b1, addr: '0, data: end_word};
                                done_next = 1'b0;
                            end
                        end
                        REQ_NODE: begin
                            if ({1'b0, s_data.node_index} < 9'(MAX_NODES)) begin
                                ram_wr = '{en: 1'b1,
                                           addr: s_data.node_index[NODE_W-1:0],
                                           data: {s_data.right_child,
                                                  s_data.left_child}};
                            end
                        end
                        REQ_DATA: begin
                            if (!done_reg) begin
                                shift_next   = s_data.data_byte;
                                bit_cnt_next = '0;
                                state_next   = ST_PRIME;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PRIME: begin
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (res_hit && pend_v_reg && !out_can_load) begin
                    // hold: re-read the same node until the pending result drains
                    ram_rd_addr = walk_node_reg;
                end else begin
                    if (res_hit) begin
                        xfer.load   = pend_v_reg;
                        pend_v_next = 1'b1;
                        pend_next   = res;
                    end
                    walk_node_next = node_step;
                    ram_rd_addr    = node_step;
                    shift_next     = shift_reg >> 1;
                    bit_cnt_next   = bit_cnt_reg + 1'b1;
                    if (res_stop) begin
                        done_next  = 1'b1;
                        state_next = ST_FLUSH;
                    end else if (bit_cnt_reg == BIT_CNT_W'(BYTE_BITS - 1)) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_v_reg) begin
                    state_next = ST_IDLE;
                end else if (out_can_load) begin
                    xfer.load      = 1'b1;
                    xfer.item.last = 1'b1;
                    pend_v_next    = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_load_from_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        xfer.load |-> pend_v_reg && out_can_load)
        else $error("result moved out without a pending result");

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !pend_v_reg)
        else $error("pending result left behind in idle");

    a_stop_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(done_reg) |-> state_reg == ST_FLUSH && pend_v_reg)
        else $error("stream stopped without a terminating result");

    a_mid_only_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        xfer.load && !xfer.item.last |-> state_reg == ST_WALK)
        else $error("non-last result outside the bit walk");

    a_prime_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PRIME |=> bit_cnt_reg == '0 && state_reg == ST_WALK)
        else $error("bit walk did not start at bit zero");

endmodule

### rtl/core/huffman_tree_walk_decoder.sv
// Huffman tree walk decoder. Valid start items (node count check, root preset) and
// tree node loads are each handled in the idle state; a start with a bad node count
// passes through the flush state to hand off its result. A data byte is walked one
// bit per cycle while the result side does not stall, against a 256-entry tree RAM
// whose registered read feeds the next address: a prime state fetches the current
// node, the walk state decodes each bit (up to eight, fewer when an end token or bad
// child stops the byte), and the flush state hands off the last result; no new item
// is accepted until the byte is done. Results pass through a one-deep hold stage and
// an output register; when the result side stalls, the walk holds on the current bit.
// The tree RAM is not cleared at reset: walking a node that was never loaded gives
// undefined results.
module huffman_tree_walk_decoder
    import hwd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    xfer_t              xfer;
    ram_wr_t            ram_wr;
    logic [NODE_W-1:0]  ram_rd_addr;
    logic [ENTRY_W-1:0] ram_rd_data;
    logic               out_can_load;
    logic               out_v_reg, out_v_next;
    out_item_t          out_reg, out_next;

    hwd_tree_ram u_tree_ram (
        .aclk    (aclk),
        .wr      (ram_wr),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    hwd_bit_walker u_walker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .out_can_load (out_can_load),
        .xfer         (xfer),
        .ram_wr       (ram_wr),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data)
    );

    assign out_can_load = !out_v_reg || m_ready;

    always_comb begin
        out_v_next = out_v_reg;
        out_next   = out_reg;
        if (xfer.load) begin
            out_v_next = 1'b1;
            out_next   = xfer.item;
        end else if (m_ready) begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else begin
            out_v_reg <= out_v_next;
        end
        out_reg <= out_next;
    end

    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

endmodule

### tb/huffman_tree_walk_decoder_tb.sv
module huffman_tree_walk_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hwd_pkg::*;

    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         DRAIN_CYCLES = 40;
    localparam int         RANDOM_ITEMS = 200;
    localparam int         MAX_REPORTS  = 40;
    localparam int         NORMAL_IDLE  = 15;
    localparam logic [1:0] REQ_UNUSED   = 2'd3;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // decoder mirror
    logic [ENTRY_W-1:0] tree_mem [TABLE_DEPTH];
    logic [NODE_W-1:0]  walk_at     = '0;
    logic               stream_idle = 1'b1;
    out_item_t          expected_decodes [$];

    int mismatches = 0;
    int items_sent = 0;
    int cycles     = 0;
    int idle_pct   = NORMAL_IDLE;

    huffman_tree_walk_decoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= idle_pct);
    end

    function automatic logic [CHILD_W-1:0] leaf_word(int value);
        return CHILD_W'(-(value + 1));
    endfunction

    function automatic out_item_t make_result(logic [7:0] sym, status_t st);
        out_item_t r;
        r.symbol = sym;
        r.status = st;
        r.last   = 1'b0;
        return r;
    endfunction

    function automatic in_item_t random_item(logic [1:0] kind);
        in_item_t it;
        it.req_type    = kind;
        it.node_count  = 15'($urandom);
        it.node_index  = 8'($urandom);
        it.left_child  = 16'($urandom);
        it.right_child = 16'($urandom);
        it.data_byte   = 8'($urandom);
        return it;
    endfunction

    function automatic void decode_item(in_item_t it);
        out_item_t          batch [$];
        logic [CHILD_W-1:0] child;
        logic [CHILD_W-1:0] leaf;
        logic               stop;
        stop = 1'b0;
        case (it.req_type)
            REQ_START: begin
                walk_at = '0;
                if (it.node_count > MAX_NODES) begin
                    stream_idle = 1'b1;
                    batch.push_back(make_result(8'd0, STAT_BAD_COUNT));
                end else begin
                    tree_mem[0] = {leaf_word(END_TOKEN), leaf_word(END_TOKEN)};
                    stream_idle = 1'b0;
                end
            end
            REQ_NODE: begin
                if (it.node_index < MAX_NODES)
                    tree_mem[it.node_index] = {it.right_child, it.left_child};
            end
            REQ_DATA: begin
                for (int b = 0; b < BYTE_BITS && !stream_idle && !stop; b++) begin
                    child = it.data_byte[b] ? tree_mem[walk_at][ENTRY_W-1:CHILD_W]
                                            : tree_mem[walk_at][CHILD_W-1:0];
                    if (!child[CHILD_W-1]) begin
                        if (child >= MAX_NODES) begin
                            walk_at     = '0;
                            stream_idle = 1'b1;
                            stop        = 1'b1;
                            batch.push_back(make_result(8'd0, STAT_BAD_CHILD));
                        end else begin
                            walk_at = child[NODE_W-1:0];
                        end
                    end else begin
                        leaf    = ~child;
                        walk_at = '0;
                        if (leaf < END_TOKEN) begin
                            batch.push_back(make_result(leaf[7:0], STAT_DATA));
                        end else begin
                            stream_idle = 1'b1;
                            stop        = 1'b1;
                            batch.push_back(make_result(8'd0,
                                (leaf == END_TOKEN) ? STAT_END : STAT_BAD_CHILD));
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            expected_decodes.push_back(batch[i]);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_REPORTS)
            $display("MISMATCH @%0d: %s", cycles, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_decodes.size() == 0) begin
                report_mismatch($sformatf("unexpected beat symbol=%0d status=%0d last=%0b",
                                          m_data.symbol, m_data.status, m_data.last));
            end else begin
                want = expected_decodes.pop_front();
                if (m_data.symbol !== want.symbol)
                    report_mismatch($sformatf("symbol %0d, expected %0d",
                                              m_data.symbol, want.symbol));
                if (m_data.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_data.status, want.status));
                if (m_data.last !== want.last)
                    report_mismatch($sformatf("last %0b, expected %0b",
                                              m_data.last, want.last));
            end
        end
    end

    // Called at a rising edge; returns at the edge that accepted the beat.
    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        decode_item(it);
        items_sent++;
    endtask

    task automatic start_stream(input int count);
        in_item_t it;
        it            = random_item(REQ_START);
        it.node_count = 15'(count);
        send_item(it);
    endtask

    task automatic load_node(input int idx, input logic [CHILD_W-1:0] lft,
                             input logic [CHILD_W-1:0] rgt);
        in_item_t it;
        it             = random_item(REQ_NODE);
        it.node_index  = 8'(idx);
        it.left_child  = lft;
        it.right_child = rgt;
        send_item(it);
    endtask

    task automatic send_byte(input logic [7:0] value);
        in_item_t it;
        it           = random_item(REQ_DATA);
        it.data_byte = value;
        send_item(it);
    endtask

    // Write every entry once so no walk can reach an unloaded node.
    task automatic test_preload_table();
        for (int i = 0; i < TABLE_DEPTH; i++)
            load_node(i, leaf_word(i), leaf_word(TABLE_DEPTH - 1 - i));
    endtask

    task automatic test_empty_tree();
        start_stream(0);
        send_byte(8'hA5);
        // stream is closed now: drop the byte
        send_byte(8'h3C);
    endtask

    task automatic test_bad_count();
        start_stream(32767);
        start_stream(MAX_NODES + 1);
    endtask

    task automatic test_leaf_symbols();
        start_stream(MAX_NODES);
        load_node(0, leaf_word(0), CHILD_W'(255));
        load_node(255, leaf_word(255), leaf_word(END_TOKEN));
        send_byte(8'h00);
        send_byte(8'h01);
        // last bit steps into node 255, next byte continues from there
        send_byte(8'h80);
        send_byte(8'hFF);
    endtask

    task automatic test_bad_children();
        start_stream(0);
        load_node(0, CHILD_W'(MAX_NODES), CHILD_W'(1));
        load_node(1, 16'h8000, CHILD_W'(2));
        load_node(2, leaf_word(END_TOKEN + 1), 16'h7FFF);
        send_byte(8'h00);
        for (int pattern = 1; pattern < 8; pattern = 2 * pattern + 1) begin
            start_stream(0);
            load_node(0, CHILD_W'(MAX_NODES), CHILD_W'(1));
            send_byte(8'(pattern));
        end
    endtask

    task automatic test_unknown_request();
        send_item(random_item(REQ_UNUSED));
    endtask

    task automatic send_noise();
        case ($urandom_range(3))
            0: send_item(random_item(REQ_UNUSED));
            1: start_stream($urandom_range(MAX_NODES + 1, 32767));
            2: send_byte(8'($urandom));
            default: load_node($urandom_range(TABLE_DEPTH - 1), 16'($urandom), 16'($urandom));
        endcase
    endtask

    task automatic send_stream();
        logic [CHILD_W-1:0] kids [2 * TABLE_DEPTH];
        int                 open_slots [$];
        int                 inner;
        int                 pick;
        int                 slot;
        inner = ($urandom_range(29) == 0) ? $urandom_range(64, TABLE_DEPTH)
                                          : $urandom_range(1, 12);
        // grow a random full tree: each new node takes a free child slot
        open_slots = '{0, 1};
        for (int n = 1; n < inner; n++) begin
            pick = $urandom_range(open_slots.size() - 1);
            slot = open_slots[pick];
            open_slots.delete(pick);
            kids[slot] = CHILD_W'(n);
            open_slots.push_back(2 * n);
            open_slots.push_back(2 * n + 1);
        end
        foreach (open_slots[j])
            kids[open_slots[j]] = leaf_word($urandom_range(255));
        if ($urandom_range(3) != 0)
            kids[open_slots[$urandom_range(open_slots.size() - 1)]] = leaf_word(END_TOKEN);
        if ($urandom_range(5) == 0) begin
            slot = $urandom_range(2 * inner - 1);
            kids[slot] = $urandom_range(1) ? CHILD_W'($urandom_range(MAX_NODES, 32767))
                                           : leaf_word($urandom_range(END_TOKEN + 1, 32767));
        end
        start_stream(($urandom_range(3) == 0) ? MAX_NODES : $urandom_range(MAX_NODES));
        for (int n = 0; n < inner; n++)
            load_node(n, kids[2 * n], kids[2 * n + 1]);
        repeat ($urandom_range(2, 12)) send_byte(8'($urandom));
    endtask

    task automatic test_random_streams();
        int first;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS) begin
            // quiet window: no gaps and no back-pressure
            idle_pct = (items_sent - first >= 50 && items_sent - first < 150) ? 0
                                                                              : NORMAL_IDLE;
            if ($urandom_range(7) == 0)
                send_noise();
            else
                send_stream();
        end
        idle_pct = NORMAL_IDLE;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_preload_table();
        test_empty_tree();
        test_bad_count();
        test_leaf_symbols();
        test_bad_children();
        test_unknown_request();
        test_random_streams();
        s_valid <= 1'b0;
        while (expected_decodes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
